// ===== sv/sfs_pkg.sv =====
`default_nettype none
package sfs_pkg;

   // Number of slots handed out by the allocator
   localparam int MAX_SLOTS = 64;

   // Field widths
   localparam int SLOT_W = 8;
   localparam int STATUS_W = 3;
   // Fill count and bump pointer must hold MAX_SLOTS itself
   localparam int CNT_W = $clog2(MAX_SLOTS + 1);
   // Index into per-slot flag storage
   localparam int IDX_W = $clog2(MAX_SLOTS);
   // Width used to compare a slot index against counts
   localparam int CMP_W = (SLOT_W > CNT_W) ? SLOT_W + 1 : CNT_W + 1;

   // Request commands
   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   // Response status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_OK                = 3'd0,
      ST_NO_SLOT           = 3'd1,
      ST_NOTHING_ALLOCATED = 3'd2,
      ST_OUT_OF_RANGE      = 3'd3,
      ST_STACK_FULL        = 3'd4
   } status_type;

   // Shift control broadcast along the stack cells
   typedef struct packed {
      logic push;
      logic pop;
   } stk_ctrl_type;

endpackage
`default_nettype wire

// ===== sv/sfs_cell.sv =====
`default_nettype none
// One stack entry: loads from the neighbor above on push, from below on pop
module sfs_cell (
   input  wire logic                          clock,
   input  wire sfs_pkg::stk_ctrl_type         ctrl,
   input  wire logic [sfs_pkg::SLOT_W-1:0]    from_above,
   input  wire logic [sfs_pkg::SLOT_W-1:0]    from_below,
   output logic      [sfs_pkg::SLOT_W-1:0]    data
);

   logic [sfs_pkg::SLOT_W-1:0] data_ff;
   logic [sfs_pkg::SLOT_W-1:0] data_in;

   // Next entry value
   always_comb begin
      data_in = data_ff;
      if (ctrl.push) begin
         data_in = from_above;
      end else if (ctrl.pop) begin
         data_in = from_below;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule
`default_nettype wire

// ===== sv/sfs_stack.sv =====
`default_nettype none
// LIFO built as a chain of shifting cells; cell 0 is the top of stack
module sfs_stack (
   input  wire logic                          clock,
   input  wire sfs_pkg::stk_ctrl_type         ctrl,
   input  wire logic [sfs_pkg::SLOT_W-1:0]    push_data,
   output logic      [sfs_pkg::SLOT_W-1:0]    top_data
);

   logic [sfs_pkg::SLOT_W-1:0] cell_data [sfs_pkg::MAX_SLOTS];

   for (genvar i = 0; i < sfs_pkg::MAX_SLOTS; i++) begin : g_cell
      logic [sfs_pkg::SLOT_W-1:0] above;
      logic [sfs_pkg::SLOT_W-1:0] below;

      // Neighbor hookup; ends of the chain take the new entry / zero
      if (i == 0) begin : g_top
         assign above = push_data;
      end else begin : g_mid_a
         assign above = cell_data[i-1];
      end
      if (i == sfs_pkg::MAX_SLOTS - 1) begin : g_bot
         assign below = '0;
      end else begin : g_mid_b
         assign below = cell_data[i+1];
      end

      sfs_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .from_above (above),
         .from_below (below),
         .data       (cell_data[i])
      );
   end

   assign top_data = cell_data[0];

endmodule
`default_nettype wire

// ===== sv/slot_allocator_free_stack_unit.sv =====
`default_nettype none
// Channel | Ports                                  | Direction
// --------+----------------------------------------+----------
// request | req_valid/ready, command, freed_slot   | in
// result  | rsp_valid/ready, slot_index, status    | out
//
// Each request is a push or pop of the cell chain plus the count and bump
// pointer update, so one transaction per clock is sustained while rsp_ready is high.
// The result shows in the cycle after acceptance in an output register; a new
// request is taken while that register is empty or being drained.
// Reset empties the stack, clears the bump pointer and all visible flags.
module slot_allocator_free_stack_unit (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic                              req_command,
   input  wire logic [sfs_pkg::SLOT_W-1:0]        req_freed_slot,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic      [sfs_pkg::SLOT_W-1:0]        rsp_slot_index,
   output logic      [sfs_pkg::STATUS_W-1:0]      rsp_status
);

   logic [sfs_pkg::CNT_W-1:0]     free_count_ff, free_count_in;
   logic [sfs_pkg::CNT_W-1:0]     high_water_ff, high_water_in;
   logic [sfs_pkg::MAX_SLOTS-1:0] visible_ff, visible_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [sfs_pkg::SLOT_W-1:0]    slot_ff, slot_in;
   sfs_pkg::status_type           status_ff, status_in;

   sfs_pkg::stk_ctrl_type         stk_ctrl;
   logic [sfs_pkg::SLOT_W-1:0]    top_data;
   logic                          fire;
   logic [sfs_pkg::CMP_W-1:0]     slot_ext;
   logic [sfs_pkg::CMP_W-1:0]     hw_ext;

   sfs_stack u_stack (
      .clock     (clock),
      .ctrl      (stk_ctrl),
      .push_data (req_freed_slot),
      .top_data  (top_data)
   );

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign fire      = req_valid && req_ready;
   assign slot_ext  = sfs_pkg::CMP_W'(req_freed_slot);
   assign hw_ext    = sfs_pkg::CMP_W'(high_water_ff);

   // Request decode and state update
   always_comb begin
      free_count_in = free_count_ff;
      high_water_in = high_water_ff;
      visible_in    = visible_ff;
      stk_ctrl      = '0;
      slot_in       = slot_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;

      if (fire) begin
         rsp_valid_in = 1'b1;
         slot_in      = '0;
         status_in    = sfs_pkg::ST_OK;
         if (req_command == sfs_pkg::CMD_ALLOC) begin
            if (free_count_ff != '0) begin
               // reuse most recently freed slot
               stk_ctrl.pop  = 1'b1;
               free_count_in = free_count_ff - 1'b1;
               slot_in       = top_data;
               visible_in[top_data[sfs_pkg::IDX_W-1:0]] = 1'b1;
            end else if (hw_ext < sfs_pkg::CMP_W'(sfs_pkg::MAX_SLOTS)) begin
               // bump pointer
               high_water_in = high_water_ff + 1'b1;
               slot_in       = sfs_pkg::SLOT_W'(high_water_ff);
               visible_in[high_water_ff[sfs_pkg::IDX_W-1:0]] = 1'b1;
            end else begin
               status_in = sfs_pkg::ST_NO_SLOT;
            end
         end else begin
            if (high_water_ff == '0) begin
               status_in = sfs_pkg::ST_NOTHING_ALLOCATED;
            end else if (slot_ext >= hw_ext ||
                         slot_ext >= sfs_pkg::CMP_W'(sfs_pkg::MAX_SLOTS)) begin
               status_in = sfs_pkg::ST_OUT_OF_RANGE;
            end else if (free_count_ff >= sfs_pkg::CNT_W'(sfs_pkg::MAX_SLOTS)) begin
               status_in = sfs_pkg::ST_STACK_FULL;
            end else begin
               stk_ctrl.push = 1'b1;
               free_count_in = free_count_ff + 1'b1;
               visible_in[req_freed_slot[sfs_pkg::IDX_W-1:0]] = 1'b0;
            end
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         free_count_ff <= '0;
         high_water_ff <= '0;
         visible_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         free_count_ff <= free_count_in;
         high_water_ff <= high_water_in;
         visible_ff    <= visible_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      slot_ff   <= slot_in;
      status_ff <= status_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_slot_index = slot_ff;
   assign rsp_status     = status_ff;

endmodule
`default_nettype wire

// ===== test/slot_alloc_checker.sv =====
`default_nettype none
// Watches both channels of the slot allocator, predicts each grant and
// compares it with the response transactions in order.
module slot_alloc_checker
   import sfs_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   input  wire logic                req_ready,
   input  wire logic                req_command,
   input  wire logic [SLOT_W-1:0]   req_freed_slot,
   input  wire logic                rsp_valid,
   input  wire logic                rsp_ready,
   input  wire logic [SLOT_W-1:0]   rsp_slot_index,
   input  wire logic [STATUS_W-1:0] rsp_status,
   output int unsigned              mismatches,
   output int unsigned              outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [SLOT_W-1:0] slot_index;
      status_type        status;
   } grant_type;

   // Shadow allocator state
   logic [SLOT_W-1:0] free_slots [MAX_SLOTS];
   logic [CNT_W-1:0]  free_depth;
   logic [CNT_W-1:0]  bump_ptr;
   logic              visible [MAX_SLOTS];

   grant_type   pending_grants [$];
   int unsigned miss_count = 0;
   int unsigned wait_count = 0;

   assign mismatches  = miss_count;
   assign outstanding = wait_count;

   // One request: pop or bump on allocate, range checks and push on free
   function automatic grant_type predict_grant(input logic cmd, input logic [SLOT_W-1:0] slot);
      grant_type g;
      g.slot_index = '0;
      g.status     = ST_OK;
      if (cmd == CMD_ALLOC) begin
         if (free_depth != 0) begin
            free_depth   = free_depth - 1'b1;
            g.slot_index = free_slots[free_depth[IDX_W-1:0]];
         end else if (int'(bump_ptr) >= MAX_SLOTS) begin
            g.status = ST_NO_SLOT;
         end else begin
            g.slot_index = SLOT_W'(bump_ptr);
            bump_ptr     = bump_ptr + 1'b1;
         end
         if (g.status == ST_OK) visible[g.slot_index[IDX_W-1:0]] = 1'b1;
      end else begin
         if (bump_ptr == 0) begin
            g.status = ST_NOTHING_ALLOCATED;
         end else if (int'(slot) >= int'(bump_ptr) || int'(slot) >= MAX_SLOTS) begin
            g.status = ST_OUT_OF_RANGE;
         end else if (int'(free_depth) >= MAX_SLOTS) begin
            g.status = ST_STACK_FULL;
         end else begin
            // double frees go through unchecked
            free_slots[free_depth[IDX_W-1:0]] = slot;
            free_depth                        = free_depth + 1'b1;
            visible[slot[IDX_W-1:0]]          = 1'b0;
         end
      end
      return g;
   endfunction

   // Requests are predicted before responses of the same edge are checked
   always @(posedge clock) begin
      grant_type want;
      if (reset) begin
         free_depth = '0;
         bump_ptr   = '0;
         foreach (visible[i]) visible[i] = 1'b0;
         pending_grants.delete();
      end else begin
         if (req_valid && req_ready)
            pending_grants.push_back(predict_grant(req_command, req_freed_slot));
         if (rsp_valid && rsp_ready) begin
            if (pending_grants.size() == 0) begin
               $error("unexpected response transaction: slot_index %0d status %0d",
                      rsp_slot_index, rsp_status);
               miss_count++;
            end else begin
               want = pending_grants.pop_front();
               if (rsp_slot_index !== want.slot_index) begin
                  $error("slot_index: expected %0d, actual %0d", want.slot_index,
                         rsp_slot_index);
                  miss_count++;
               end
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_status);
                  miss_count++;
               end
            end
         end
      end
      wait_count = pending_grants.size();
   end

endmodule
`default_nettype wire

// ===== test/tb.sv =====
`default_nettype none
module tb;
   import sfs_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PHASES      = 8;
   localparam int PHASE_ITEMS = 105;
   localparam int CYCLE_LIMIT = 200000;

   logic              clock          = 1'b0;
   logic              reset          = 1'b1;
   logic              req_valid      = 1'b0;
   logic              req_command    = CMD_ALLOC;
   logic [SLOT_W-1:0] req_freed_slot = '0;
   logic              rsp_ready      = 1'b0;
   wire logic                req_ready;
   wire logic                rsp_valid;
   wire logic [SLOT_W-1:0]   rsp_slot_index;
   wire logic [STATUS_W-1:0] rsp_status;
   int unsigned mismatches;
   int unsigned outstanding;

   // Odds of an idle burst per transaction, 0 = no idling
   int unsigned gap_odds  = 4;
   int unsigned cycles    = 0;
   // Percentage of allocates in each random phase
   int unsigned alloc_pct [PHASES] = '{90, 15, 90, 50, 15, 50, 90, 50};

   slot_allocator_free_stack_unit dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_command    (req_command),
      .req_freed_slot (req_freed_slot),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_slot_index (rsp_slot_index),
      .rsp_status     (rsp_status)
   );

   slot_alloc_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_command    (req_command),
      .req_freed_slot (req_freed_slot),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_slot_index (rsp_slot_index),
      .rsp_status     (rsp_status),
      .mismatches     (mismatches),
      .outstanding    (outstanding)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Response backpressure in random bursts
   initial begin
      forever begin
         @(posedge clock);
         if (gap_odds != 0 && $urandom_range(1, gap_odds + 4) == 1) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   // Optional idle burst, then one request held until accepted
   task automatic issue_request(input logic cmd, input logic [SLOT_W-1:0] slot);
      if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_command    <= cmd;
      req_freed_slot <= slot;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Mostly in-range indices, with boundaries and the full 8-bit range
   function automatic logic [SLOT_W-1:0] pick_slot();
      logic [SLOT_W-1:0] s;
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 3))
               0: s = '0;
               1: s = SLOT_W'(MAX_SLOTS - 1);
               2: s = SLOT_W'(MAX_SLOTS);
               default: s = '1;
            endcase
         end
         1, 2:    s = SLOT_W'($urandom_range(0, 255));
         default: s = SLOT_W'($urandom_range(0, MAX_SLOTS - 1));
      endcase
      return s;
   endfunction

   initial begin
      logic cmd;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: free before any grant, range edges, reuse order, double free
      issue_request(CMD_FREE, 8'd0);
      issue_request(CMD_FREE, 8'd255);
      issue_request(CMD_ALLOC, 8'd0);
      issue_request(CMD_FREE, 8'd1);
      issue_request(CMD_FREE, 8'd255);
      issue_request(CMD_FREE, 8'd0);
      issue_request(CMD_ALLOC, 8'd0);
      issue_request(CMD_ALLOC, 8'd0);
      issue_request(CMD_ALLOC, 8'd0);
      issue_request(CMD_FREE, 8'd2);
      issue_request(CMD_FREE, 8'd1);
      issue_request(CMD_ALLOC, 8'd0);
      issue_request(CMD_FREE, 8'd1);
      issue_request(CMD_FREE, 8'd1);
      issue_request(CMD_ALLOC, 8'd0);
      issue_request(CMD_ALLOC, 8'd0);
      issue_request(CMD_FREE, 8'd128);
      issue_request(CMD_ALLOC, 8'd255);

      // Random phases: allocate-heavy runs hit the limit, free-heavy runs fill the stack
      for (int p = 0; p < PHASES; p++) begin
         gap_odds = (p == PHASES - 1 || p % 3 == 1) ? 0 : 6;
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            cmd = ($urandom_range(0, 99) < alloc_pct[p]) ? CMD_ALLOC : CMD_FREE;
            issue_request(cmd, pick_slot());
         end
      end
      req_valid <= 1'b0;

      // Drain, then allow the output register to settle
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatches == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
`default_nettype wire
